// ===== hdl/fdtd_pkg.sv =====
// shared types, constants and helpers for the 2d tmz grid stepper
// used by fdtd_ctrl, fdtd_dp and fdtd_2d_tmz_grid_step; depends on nothing
package fdtd_pkg;

   localparam int GRID_X    = 200;
   localparam int GRID_Y    = 200;
   localparam int FRAC_BITS = 20;

   localparam int CELLS = GRID_X * GRID_Y;
   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int AW    = $clog2(CELLS);
   localparam int MW    = (XW > YW) ? XW : YW;
   localparam int CW    = ((MW > 8) ? MW : 8) + 1;
   localparam int SQ_W  = 2 * CW + 1;

   localparam int DIFF_W  = 35;
   localparam int MAG_W   = 34;
   localparam int HALF_W  = 17;
   localparam int COEF_W  = 31;
   localparam int PART_W  = COEF_W + HALF_W;
   localparam int PROD_W  = PART_W + HALF_W;
   localparam int SPROD_W = PROD_W + 1;

   localparam logic REQ_STEP   = 1'b0;
   localparam logic REQ_READ   = 1'b1;
   localparam logic REPLY_STEP = 1'b0;
   localparam logic REPLY_READ = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_E_COEFF    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HX_COEFF   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HY_COEFF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CYL_X      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CYL_Y      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CYL_RAD_SQ = 3'd7;

   typedef logic [XW-1:0]        col_type;
   typedef logic [YW-1:0]        row_type;
   typedef logic [AW-1:0]        addr_type;
   typedef logic signed [31:0]   word_type;

   typedef enum logic [2:0] {
      PASS_CLEAR, PASS_HX, PASS_HY, PASS_SRC, PASS_EZ, PASS_EDGE, PASS_READ
   } pass_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_DIFF, ST_MUL0, ST_MUL1, ST_ACC, ST_WR, ST_REPLY
   } state_type;

   typedef struct packed {
      pass_type pass;
      col_type  col;
      row_type  row;
      logic     rd;
      logic     diff;
      logic     mul_lo;
      logic     mul_hi;
      logic     acc;
      logic     wr;
      logic     load;
      logic     reply;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   typedef struct packed {
      logic [COEF_W-1:0] e_coeff;
      logic [COEF_W-1:0] hx_coeff;
      logic [COEF_W-1:0] hy_coeff;
      logic [7:0]        source_x;
      logic [7:0]        source_y;
      logic [7:0]        cylinder_x;
      logic [7:0]        cylinder_y;
      logic [17:0]       cylinder_radius_sq;
   } csr_type;

   function automatic addr_type cell_addr(col_type x, row_type y);
      return AW'(AW'(x) * AW'(GRID_Y) + AW'(y));
   endfunction

   function automatic word_type sat32(logic signed [SPROD_W-1:0] v);
      if (v[SPROD_W-1:31] == '0 || v[SPROD_W-1:31] == '1) begin
         return v[31:0];
      end else if (v[SPROD_W-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

endpackage

// ===== hdl/fdtd_2d_tmz_grid_step.sv =====
// top level of the 2d tmz yee grid stepper: register file, sequencer, datapath
// depends on fdtd_pkg, fdtd_ctrl and fdtd_dp
//
// usage:
//  - req channel (valid/ready): req_type 0 advances all three grids one time
//    step with req_source_value added at the source cell; req_type 1 reads Ez
//    at (req_read_x, req_read_y)
//  - rsp channel (valid/ready): one reply per request, rsp_reply_kind tells
//    step done or read data; rsp_ez_value is zero on a step reply
//  - csr channel: index and data, always ready, write only while idle
//  - a read passes the read and reply states between accept and reply
//  - a step runs read, diff, low and high multiply, accumulate and write
//    for each cell of the Hx, Hy and Ez passes, and read and write for the
//    source and edge copy passes; the single multiplier is used twice per cell
//  - after reset the grids are cleared one cell a cycle, and no request is
//    taken until the clear is done
//  - a finished reply sits in an output register; the next request is taken
//    while it waits, but its own reply waits for that register to drain
module fdtd_2d_tmz_grid_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic signed [31:0]               req_source_value,
   input  logic [7:0]                       req_read_x,
   input  logic [7:0]                       req_read_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_reply_kind,
   output logic signed [31:0]               rsp_ez_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fdtd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_data
);
   import fdtd_pkg::*;

   csr_type    csr_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.e_coeff            <= 31'd279340646;
         csr_ff.hx_coeff           <= 31'd1968;
         csr_ff.hy_coeff           <= 31'd1968;
         csr_ff.source_x           <= 8'd10;
         csr_ff.source_y           <= 8'd100;
         csr_ff.cylinder_x         <= 8'd100;
         csr_ff.cylinder_y         <= 8'd100;
         csr_ff.cylinder_radius_sq <= 18'd400;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_E_COEFF:    csr_ff.e_coeff            <= csr_data[30:0];
            CSR_HX_COEFF:   csr_ff.hx_coeff           <= csr_data[30:0];
            CSR_HY_COEFF:   csr_ff.hy_coeff           <= csr_data[30:0];
            CSR_SOURCE_X:   csr_ff.source_x           <= csr_data[7:0];
            CSR_SOURCE_Y:   csr_ff.source_y           <= csr_data[7:0];
            CSR_CYL_X:      csr_ff.cylinder_x         <= csr_data[7:0];
            CSR_CYL_Y:      csr_ff.cylinder_y         <= csr_data[7:0];
            CSR_CYL_RAD_SQ: csr_ff.cylinder_radius_sq <= csr_data[17:0];
            default:        csr_ff.e_coeff            <= csr_ff.e_coeff;
         endcase
      end
   end

   fdtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .cmd       (cmd),
      .status    (status)
   );

   fdtd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr              (csr_ff),
      .req_source_value (req_source_value),
      .req_read_x       (req_read_x),
      .req_read_y       (req_read_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_ez_value     (rsp_ez_value)
   );

`ifndef SYNTHESIS
   // a reply is only loaded when the output register is free
   a_reply_free: assert property (@(posedge clock) disable iff (reset)
      cmd.reply |-> !(rsp_valid && !rsp_ready))
      else $error("reply loaded over a pending reply");

   // one request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while one is in flight");

   // memory read and write phases never overlap
   a_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd && cmd.wr))
      else $error("read and write phase together");
`endif

endmodule

// ===== hdl/fdtd_ctrl.sv =====
// sequencer for the grid stepper: pass order, cell counters, per-cell phases
// depends on fdtd_pkg; drives fdtd_dp through cmd_type
module fdtd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   output fdtd_pkg::cmd_type   cmd,
   input  fdtd_pkg::status_type status
);
   import fdtd_pkg::*;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;
   col_type   col_ff, col_in;
   row_type   row_ff, row_in;
   logic      cell_last;

   function automatic col_type col_first(pass_type p);
      return (p == PASS_EZ) ? col_type'(1) : '0;
   endfunction

   function automatic col_type col_last(pass_type p);
      unique case (p)
         PASS_HY:                      return col_type'(GRID_X - 2);
         PASS_HX, PASS_EZ, PASS_EDGE,
         PASS_CLEAR:                   return col_type'(GRID_X - 1);
         default:                      return '0;
      endcase
   endfunction

   function automatic row_type row_first(pass_type p);
      return (p == PASS_EZ) ? row_type'(1) : '0;
   endfunction

   function automatic row_type row_last(pass_type p);
      unique case (p)
         PASS_HX:                      return row_type'(GRID_Y - 2);
         PASS_HY, PASS_EZ, PASS_EDGE,
         PASS_CLEAR:                   return row_type'(GRID_Y - 1);
         default:                      return '0;
      endcase
   endfunction

   assign cell_last = (col_ff == col_last(pass_ff)) && (row_ff == row_last(pass_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pass_ff  <= PASS_CLEAR;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // next state, pass and cell position
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      unique case (state_ff)
         ST_CLEAR, ST_WR: begin
            if (!cell_last) begin
               state_in = (state_ff == ST_CLEAR) ? ST_CLEAR : ST_RD;
               if (row_ff == row_last(pass_ff)) begin
                  row_in = row_first(pass_ff);
                  col_in = col_ff + col_type'(1);
               end else begin
                  row_in = row_ff + row_type'(1);
               end
            end else begin
               state_in = ST_RD;
               unique case (pass_ff)
                  PASS_HX:   pass_in = PASS_HY;
                  PASS_HY:   pass_in = PASS_SRC;
                  PASS_SRC:  pass_in = PASS_EZ;
                  PASS_EZ:   pass_in = PASS_EDGE;
                  PASS_EDGE: state_in = ST_REPLY;
                  default:   state_in = ST_IDLE;
               endcase
               col_in = col_first(pass_in);
               row_in = row_first(pass_in);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RD;
               pass_in  = (req_type == REQ_READ) ? PASS_READ : PASS_HX;
               col_in   = '0;
               row_in   = '0;
            end
         end
         ST_RD: begin
            unique case (pass_ff)
               PASS_HX, PASS_HY, PASS_EZ: state_in = ST_DIFF;
               PASS_SRC, PASS_EDGE:       state_in = ST_WR;
               PASS_READ:                 state_in = ST_REPLY;
               default:                   state_in = ST_IDLE;
            endcase
         end
         ST_DIFF:  state_in = ST_MUL0;
         ST_MUL0:  state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_ACC;
         ST_ACC:   state_in = ST_WR;
         ST_REPLY: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // commands to the datapath
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      cmd.pass   = pass_ff;
      cmd.col    = col_ff;
      cmd.row    = row_ff;
      cmd.rd     = (state_ff == ST_RD);
      cmd.diff   = (state_ff == ST_DIFF);
      cmd.mul_lo = (state_ff == ST_MUL0);
      cmd.mul_hi = (state_ff == ST_MUL1);
      cmd.acc    = (state_ff == ST_ACC);
      cmd.wr     = (state_ff == ST_WR) || (state_ff == ST_CLEAR);
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.reply  = (state_ff == ST_REPLY) && !status.rsp_busy;
   end

endmodule

// ===== hdl/fdtd_dp.sv =====
// datapath of the grid stepper: the three field memories, the shared
// multiplier with saturation, request latch and reply register; uses fdtd_pkg
module fdtd_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  fdtd_pkg::cmd_type     cmd,
   output fdtd_pkg::status_type  status,
   input  fdtd_pkg::csr_type     csr,
   input  logic signed [31:0]    req_source_value,
   input  logic [7:0]            req_read_x,
   input  logic [7:0]            req_read_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_reply_kind,
   output logic signed [31:0]    rsp_ez_value
);
   import fdtd_pkg::*;

   word_type ez_mem [CELLS];
   word_type hx_mem [CELLS];
   word_type hy_mem [CELLS];

   word_type ez_a_ff, ez_b_ff, hx_a_ff, hx_b_ff, hy_a_ff, hy_b_ff;
   addr_type ez_a_addr, ez_b_addr, hx_b_addr, hy_b_addr, here_addr, ez_w_addr, src_addr;
   addr_type rd_addr;
   word_type ez_w_data, hx_w_data, hy_w_data;
   logic     ez_we, hx_we, hy_we;

   word_type src_value_ff;
   logic [7:0] rd_x_ff, rd_y_ff;
   logic     src_ok, rd_ok;

   logic signed [DIFF_W-1:0] diff;
   logic [MAG_W-1:0]  mag_ff;
   logic              neg_ff, sub_ff, zero_ff;
   word_type          old_ff, old_in;
   logic              sub_in;
   logic [COEF_W-1:0] coef;
   logic [HALF_W-1:0] mul_in;
   logic [PART_W-1:0] mul_out, plo_ff, phi_ff;
   logic [PROD_W-1:0] psum;
   logic signed [SPROD_W-1:0] sprod_ff, sprod_in, scaled, term, upd_sum, src_sum;
   word_type          upd;

   logic signed [CW-1:0]   dx, dy;
   logic signed [2*CW-1:0] dxx, dyy;
   logic [SQ_W-1:0]        dist_sq;
   logic                   in_cyl;

   logic    on_top, on_bot, on_lft, on_rgt, edge_cell;
   col_type nb_col;
   row_type nb_row;

   logic rsp_valid_ff, rsp_kind_ff;
   word_type rsp_value_ff;

   assign src_ok = (32'(csr.source_x) < 32'(GRID_X)) && (32'(csr.source_y) < 32'(GRID_Y));
   assign rd_ok  = (32'(rd_x_ff) < 32'(GRID_X)) && (32'(rd_y_ff) < 32'(GRID_Y));
   assign src_addr = src_ok ? cell_addr(col_type'(csr.source_x), row_type'(csr.source_y)) : '0;
   assign rd_addr  = rd_ok ? cell_addr(col_type'(rd_x_ff), row_type'(rd_y_ff)) : '0;
   assign here_addr = cell_addr(cmd.col, cmd.row);

   // edge copy source: inner neighbour, corners excluded
   always_comb begin
      on_top    = (cmd.row == '0);
      on_bot    = (cmd.row == row_type'(GRID_Y - 1));
      on_lft    = (cmd.col == '0);
      on_rgt    = (cmd.col == col_type'(GRID_X - 1));
      edge_cell = (on_top || on_bot) != (on_lft || on_rgt);
      nb_col    = cmd.col;
      nb_row    = cmd.row;
      if (on_top) begin
         nb_row = row_type'(1);
      end else if (on_bot) begin
         nb_row = row_type'(GRID_Y - 2);
      end else if (on_lft) begin
         nb_col = col_type'(1);
      end else if (on_rgt) begin
         nb_col = col_type'(GRID_X - 2);
      end
   end

   always_comb begin
      unique case (cmd.pass)
         PASS_HX:   ez_a_addr = cell_addr(cmd.col, cmd.row + row_type'(1));
         PASS_HY:   ez_a_addr = cell_addr(cmd.col + col_type'(1), cmd.row);
         PASS_EDGE: ez_a_addr = cell_addr(nb_col, nb_row);
         default:   ez_a_addr = here_addr;
      endcase
      unique case (cmd.pass)
         PASS_SRC:  ez_b_addr = src_addr;
         PASS_READ: ez_b_addr = rd_addr;
         default:   ez_b_addr = here_addr;
      endcase
      hx_b_addr = (cmd.row == '0) ? here_addr : cell_addr(cmd.col, cmd.row - row_type'(1));
      hy_b_addr = (cmd.col == '0) ? here_addr : cell_addr(cmd.col - col_type'(1), cmd.row);
   end

   // memories: registered reads, one write each
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         ez_a_ff <= ez_mem[ez_a_addr];
         ez_b_ff <= ez_mem[ez_b_addr];
         hx_a_ff <= hx_mem[here_addr];
         hx_b_ff <= hx_mem[hx_b_addr];
         hy_a_ff <= hy_mem[here_addr];
         hy_b_ff <= hy_mem[hy_b_addr];
      end
      if (ez_we) begin
         ez_mem[ez_w_addr] <= ez_w_data;
      end
      if (hx_we) begin
         hx_mem[here_addr] <= hx_w_data;
      end
      if (hy_we) begin
         hy_mem[here_addr] <= hy_w_data;
      end
   end

   // cylinder membership of the current cell
   always_comb begin
      dx      = signed'(CW'(cmd.col)) - signed'(CW'(csr.cylinder_x));
      dy      = signed'(CW'(cmd.row)) - signed'(CW'(csr.cylinder_y));
      dxx     = dx * dx;
      dyy     = dy * dy;
      dist_sq = SQ_W'(unsigned'(dxx)) + SQ_W'(unsigned'(dyy));
      in_cyl  = dist_sq <= SQ_W'(csr.cylinder_radius_sq);
   end

   // difference or curl of the current cell
   always_comb begin
      unique case (cmd.pass)
         PASS_HX: begin
            diff   = DIFF_W'(ez_a_ff) - DIFF_W'(ez_b_ff);
            old_in = hx_a_ff;
            sub_in = 1'b1;
         end
         PASS_HY: begin
            diff   = DIFF_W'(ez_a_ff) - DIFF_W'(ez_b_ff);
            old_in = hy_a_ff;
            sub_in = 1'b0;
         end
         default: begin
            diff   = (DIFF_W'(hy_a_ff) - DIFF_W'(hy_b_ff)) - (DIFF_W'(hx_a_ff) - DIFF_W'(hx_b_ff));
            old_in = ez_b_ff;
            sub_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.pass)
         PASS_HX: coef = csr.hx_coeff;
         PASS_HY: coef = csr.hy_coeff;
         default: coef = csr.e_coeff;
      endcase
      mul_in   = cmd.mul_hi ? mag_ff[MAG_W-1:HALF_W] : mag_ff[HALF_W-1:0];
      mul_out  = PART_W'(coef) * PART_W'(mul_in);
      psum     = (PROD_W'(phi_ff) << HALF_W) + PROD_W'(plo_ff);
      sprod_in = neg_ff ? -signed'({1'b0, psum}) : signed'({1'b0, psum});
      // floor shift of the signed product
      scaled   = sprod_ff >>> FRAC_BITS;
      term     = sub_ff ? -scaled : scaled;
      upd_sum  = SPROD_W'(old_ff) + term;
      upd      = sat32(upd_sum);
      src_sum  = SPROD_W'(ez_b_ff) + SPROD_W'(src_value_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         neg_ff  <= diff[DIFF_W-1];
         mag_ff  <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
         old_ff  <= old_in;
         sub_ff  <= sub_in;
         zero_ff <= in_cyl;
      end
      if (cmd.mul_lo) begin
         plo_ff <= mul_out;
      end
      if (cmd.mul_hi) begin
         phi_ff <= mul_out;
      end
      if (cmd.acc) begin
         sprod_ff <= sprod_in;
      end
      if (cmd.load) begin
         src_value_ff <= req_source_value;
         rd_x_ff      <= req_read_x;
         rd_y_ff      <= req_read_y;
      end
   end

   // write port selection
   always_comb begin
      ez_we     = 1'b0;
      hx_we     = 1'b0;
      hy_we     = 1'b0;
      ez_w_addr = here_addr;
      ez_w_data = upd;
      hx_w_data = upd;
      hy_w_data = upd;
      if (cmd.wr) begin
         unique case (cmd.pass)
            PASS_CLEAR: begin
               ez_we     = 1'b1;
               hx_we     = 1'b1;
               hy_we     = 1'b1;
               ez_w_data = '0;
               hx_w_data = '0;
               hy_w_data = '0;
            end
            PASS_HX: hx_we = 1'b1;
            PASS_HY: hy_we = 1'b1;
            PASS_SRC: begin
               ez_we     = src_ok;
               ez_w_addr = src_addr;
               ez_w_data = sat32(src_sum);
            end
            PASS_EZ: begin
               ez_we     = 1'b1;
               ez_w_data = zero_ff ? '0 : upd;
            end
            PASS_EDGE: begin
               ez_we     = edge_cell;
               ez_w_data = ez_a_ff;
            end
            default: ez_we = 1'b0;
         endcase
      end
   end

   // reply register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.reply) begin
         rsp_kind_ff  <= (cmd.pass == PASS_READ) ? REPLY_READ : REPLY_STEP;
         rsp_value_ff <= (cmd.pass == PASS_READ && rd_ok) ? ez_b_ff : '0;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_kind  = rsp_kind_ff;
   assign rsp_ez_value    = rsp_value_ff;

endmodule

// ===== dv/tb_fdtd_2d_tmz_grid_step.sv =====
// self-checking bench for fdtd_2d_tmz_grid_step: directed table, then random requests
// keeps its own copy of the Ez/Hx/Hy grids and registers; depends on fdtd_pkg
module tb_fdtd_2d_tmz_grid_step;
   import fdtd_pkg::*;

   localparam int NX = 200;
   localparam int NY = 200;
   localparam int FB = 20;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = REQ_READ;
   logic signed [31:0]      req_source_value = '0;
   logic [7:0]              req_read_x = '0;
   logic [7:0]              req_read_y = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_reply_kind;
   logic signed [31:0]      rsp_ez_value;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [31:0]             csr_data = '0;

   fdtd_2d_tmz_grid_step dut (.*);

   always #5 clock = ~clock;

   typedef struct {
      logic        kind;
      logic [31:0] value;
   } reply_type;

   typedef struct {
      logic        kind;
      logic [31:0] src;
      logic [7:0]  x;
      logic [7:0]  y;
      bit          typed;
      logic [31:0] value;
   } stim_type;

   // mirrored grids and registers
   logic signed [31:0] ez_m [NX*NY];
   logic signed [31:0] hx_m [NX*NY];
   logic signed [31:0] hy_m [NX*NY];
   logic [30:0] e_c, hx_c, hy_c;
   logic [7:0]  src_x, src_y, cyl_x, cyl_y;
   logic [17:0] rad_sq;

   reply_type replies_due[$];
   int     errors = 0;
   int     long_hold = 0;
   bit     no_idle = 0;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // floor(coeff*diff / 2^FB), pinned at +-2^42 when the product passes 2^62
   function automatic longint scaled(logic [30:0] c, longint d);
      longint unsigned mag, p, lim;
      bit neg;
      neg = d < 0;
      mag = neg ? longint'(-d) : d;
      lim = 64'd1 << 62;
      if (c != 0 && mag > lim / c) return neg ? -(longint'(1) << 42) : (longint'(1) << 42);
      p = mag * c;
      if (neg) return -longint'((p + ((64'd1 << FB) - 1)) >> FB);
      return longint'(p >> FB);
   endfunction

   function automatic void grid_advance(logic signed [31:0] srcv);
      int a;
      longint dx, dy, curl;
      for (int i = 0; i < NX; i++)
         for (int j = 0; j < NY - 1; j++) begin
            a = i*NY + j;
            hx_m[a] = clamp32(longint'(hx_m[a])
                      - scaled(hx_c, longint'(ez_m[a+1]) - longint'(ez_m[a])));
         end
      for (int i = 0; i < NX - 1; i++)
         for (int j = 0; j < NY; j++) begin
            a = i*NY + j;
            hy_m[a] = clamp32(longint'(hy_m[a])
                      + scaled(hy_c, longint'(ez_m[a+NY]) - longint'(ez_m[a])));
         end
      if (src_x < NX && src_y < NY) begin
         a = src_x*NY + src_y;
         ez_m[a] = clamp32(longint'(ez_m[a]) + longint'(srcv));
      end
      for (int i = 1; i < NX; i++)
         for (int j = 1; j < NY; j++) begin
            a = i*NY + j;
            dx = i - longint'(cyl_x);
            dy = j - longint'(cyl_y);
            if (dx*dx + dy*dy <= longint'(rad_sq)) begin
               ez_m[a] = '0;
            end else begin
               curl = (longint'(hy_m[a]) - longint'(hy_m[a-NY]))
                    - (longint'(hx_m[a]) - longint'(hx_m[a-1]));
               ez_m[a] = clamp32(longint'(ez_m[a]) + scaled(e_c, curl));
            end
         end
      // edges from inner neighbors, corners left alone
      for (int i = 1; i < NX - 1; i++) begin
         ez_m[i*NY] = ez_m[i*NY + 1];
         ez_m[i*NY + NY-1] = ez_m[i*NY + NY-2];
      end
      for (int j = 1; j < NY - 1; j++) begin
         ez_m[j] = ez_m[NY + j];
         ez_m[(NX-1)*NY + j] = ez_m[(NX-2)*NY + j];
      end
   endfunction

   function automatic reply_type predict_reply(logic kind, logic [31:0] srcv,
                                               logic [7:0] x, logic [7:0] y);
      reply_type r;
      r.kind = (kind == REQ_STEP) ? REPLY_STEP : REPLY_READ;
      r.value = '0;
      if (kind == REQ_STEP) grid_advance(srcv);
      else if (x < NX && y < NY) r.value = ez_m[x*NY + y];
      return r;
   endfunction

   task automatic send_req(logic kind, logic [31:0] srcv, logic [7:0] x, logic [7:0] y,
                           bit typed = 0, logic [31:0] value = '0);
      int gap;
      reply_type r;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_source_value <= srcv;
      req_read_x <= x;
      req_read_y <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_reply(kind, srcv, x, y);
      if (typed) r.value = value;
      replies_due.push_back(r);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_E_COEFF:    e_c = d[30:0];
         CSR_HX_COEFF:   hx_c = d[30:0];
         CSR_HY_COEFF:   hy_c = d[30:0];
         CSR_SOURCE_X:   src_x = d[7:0];
         CSR_SOURCE_Y:   src_y = d[7:0];
         CSR_CYL_X:      cyl_x = d[7:0];
         CSR_CYL_Y:      cyl_y = d[7:0];
         CSR_CYL_RAD_SQ: rad_sq = d[17:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_all(logic [31:0] ec, logic [31:0] hxc, logic [31:0] hyc,
                              logic [7:0] sx, logic [7:0] sy, logic [7:0] cx,
                              logic [7:0] cy, logic [17:0] rs);
      csr_write(CSR_E_COEFF, ec);
      csr_write(CSR_HX_COEFF, hxc);
      csr_write(CSR_HY_COEFF, hyc);
      csr_write(CSR_SOURCE_X, {16'h0, 8'($urandom_range(0, 255)), sx});
      csr_write(CSR_SOURCE_Y, {16'h0, 8'($urandom_range(0, 255)), sy});
      csr_write(CSR_CYL_X, {24'h0, cx});
      csr_write(CSR_CYL_Y, {24'h0, cy});
      csr_write(CSR_CYL_RAD_SQ, {14'h3fff, rs});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly reads near the source, one or two steps per batch
   task automatic random_batch(int n, int steps);
      int step_at [2];
      logic [7:0] x, y;
      step_at[0] = $urandom_range(0, n-1);
      step_at[1] = (steps > 1) ? $urandom_range(0, n-1) : -1;
      for (int k = 0; k < n; k++) begin
         if (k == step_at[0] || k == step_at[1]) begin
            send_req(REQ_STEP, $urandom, 8'($urandom), 8'($urandom));
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               x = 8'($urandom_range(0, 255));
               y = 8'($urandom_range(0, 255));
            end else begin
               x = (src_x < NX) ? 8'(src_x + $urandom_range(0, 2) - 1)
                                : 8'($urandom_range(0, 199));
               y = (src_y < NY) ? 8'(src_y + $urandom_range(0, 2) - 1)
                                : 8'($urandom_range(0, 199));
            end
            send_req(REQ_READ, $urandom, x, y);
         end
      end
   endtask

   // response side
   initial begin
      int gap;
      reply_type r;
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 4);
         if (long_hold > 0) begin
            gap = long_hold;
            long_hold = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (replies_due.size() == 0) begin
            $error("reply with nothing outstanding: kind %0d value %0d",
                   rsp_reply_kind, rsp_ez_value);
            errors++;
         end else begin
            r = replies_due.pop_front();
            if (rsp_reply_kind !== r.kind) begin
               $error("reply_kind: expected %0d, got %0d", r.kind, rsp_reply_kind);
               errors++;
            end
            if (rsp_ez_value !== r.value) begin
               $error("ez_value: expected %0d, got %0d", $signed(r.value), rsp_ez_value);
               errors++;
            end
         end
      end
   end

   initial begin
      #400_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      stim_type tbl [$];
      for (int a = 0; a < NX*NY; a++) begin
         ez_m[a] = '0;
         hx_m[a] = '0;
         hy_m[a] = '0;
      end
      e_c = 31'd279340646;
      hx_c = 31'd1968;
      hy_c = 31'd1968;
      src_x = 8'd10;
      src_y = 8'd100;
      cyl_x = 8'd100;
      cyl_y = 8'd100;
      rad_sq = 18'd400;

      // cleared and off-grid reads give zero, then two steps and reads near source
      tbl = '{
         '{REQ_READ, 32'hffff_ffff, 8'd0,   8'd0,   1, 32'd0},
         '{REQ_READ, 32'h0,         8'd199, 8'd199, 1, 32'd0},
         '{REQ_READ, 32'h8000_0000, 8'd255, 8'd255, 1, 32'd0},
         '{REQ_READ, 32'h7fff_ffff, 8'd200, 8'd5,   1, 32'd0},
         '{REQ_READ, 32'h0,         8'd5,   8'd200, 1, 32'd0},
         '{REQ_STEP, 32'h7fff_ffff, 8'hff,  8'hff,  1, 32'd0},
         '{REQ_READ, 32'h0,         8'd10,  8'd100, 0, 32'd0},
         '{REQ_READ, 32'h0,         8'd11,  8'd100, 0, 32'd0},
         '{REQ_READ, 32'h0,         8'd10,  8'd101, 0, 32'd0},
         '{REQ_READ, 32'h0,         8'd100, 8'd100, 1, 32'd0},
         '{REQ_STEP, 32'h8000_0000, 8'd0,   8'd0,   1, 32'd0},
         '{REQ_READ, 32'h0,         8'd10,  8'd100, 0, 32'd0},
         '{REQ_READ, 32'h0,         8'd9,   8'd100, 0, 32'd0},
         '{REQ_READ, 32'h0,         8'd10,  8'd99,  0, 32'd0},
         '{REQ_READ, 32'h0,         8'd0,   8'd100, 0, 32'd0},
         '{REQ_READ, 32'h0,         8'd255, 8'd0,   1, 32'd0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (tbl[k])
         send_req(tbl[k].kind, tbl[k].src, tbl[k].x, tbl[k].y, tbl[k].typed, tbl[k].value);
      drain();

      // max coefficients, source in a corner, point cylinder, to push updates into saturation
      program_all(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                  8'd0, 8'd0, 8'd1, 8'd1, 18'd0);
      send_req(REQ_STEP, 32'h7fff_ffff, 8'd0, 8'd0);
      send_req(REQ_READ, 32'h0, 8'd0, 8'd0);
      send_req(REQ_READ, 32'h0, 8'd1, 8'd1);
      // hold the reply side off so the block backs up on its input
      long_hold = 300;
      no_idle = 1;
      for (int k = 0; k < 12; k++)
         send_req(REQ_READ, $urandom, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      no_idle = 0;
      drain();

      // zero coefficients, source outside the grid, cylinder covering everything
      program_all(32'h0, 32'h0, 32'h8000_0000, 8'd255, 8'd200, 8'd199, 8'd199, 18'h3ffff);
      random_batch(20, 1);
      drain();

      // random coefficients, source on an edge inside a small cylinder
      program_all($urandom_range(0, 32'h4000_0000), $urandom_range(0, 32'h0100_0000),
                  $urandom, 8'd199, 8'd50, 8'd190, 8'd50, 18'd100);
      random_batch(20, 1);
      drain();

      // back to field-like values, source in the open
      program_all(32'd279340646, $urandom_range(0, 4000), $urandom_range(0, 4000),
                  8'($urandom_range(20, 180)), 8'($urandom_range(20, 180)),
                  8'($urandom_range(0, 199)), 8'($urandom_range(0, 199)),
                  18'($urandom_range(0, 900)));
      random_batch(30, 2);
      drain();

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
